// File: rtl/core/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// Clocked check that also runs through reset.
`define ASSERT_CLK_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");

`endif

// File: rtl/core/tdhi_pkg.sv
// Package for the time-of-day hue interpolator: widths, breakpoint tables, job types.
package tdhi_pkg;

    localparam int TIME_W         = 21;
    localparam int HUE_W          = 15;
    localparam int TIME_FRAC_BITS = 4;
    localparam int HUE_FRAC_BITS  = 6;

    localparam int SEG_N      = 11;
    localparam int SEG_W      = 4;
    localparam int HUE_DEG_W  = 9;
    localparam int MAG_W      = 7;
    localparam int DT_W       = 18;   // longest segment is three hours
    localparam int PROD_W     = 24;   // mag * dt
    localparam int Q_W        = 13;   // quotient never exceeds mag << HUE_FRAC_BITS
    localparam int DIV_W      = 12;
    localparam int RECIP_W    = 23;
    localparam int PQ_W       = PROD_W + RECIP_W;
    localparam int R_W        = PROD_W + 1;
    localparam int SUM_W      = HUE_W + 1;
    localparam int RECIP_SHIFT = 32;

    localparam int HOUR_TICKS = 3600 << TIME_FRAC_BITS;
    // The input range is under two days, so one subtract reduces it.
    localparam logic [TIME_W-1:0] DAY_TICKS = TIME_W'(24 * HOUR_TICKS);

    // Span of h hours times 2^HUE_FRAC_BITS in the numerator collapses to
    // a divide by h * UNIT_DIV.
    localparam int UNIT_DIV = HOUR_TICKS >> HUE_FRAC_BITS;
    localparam longint RECIP_1 = (longint'(1) << RECIP_SHIFT) / (UNIT_DIV * 1);
    localparam longint RECIP_2 = (longint'(1) << RECIP_SHIFT) / (UNIT_DIV * 2);
    localparam longint RECIP_3 = (longint'(1) << RECIP_SHIFT) / (UNIT_DIV * 3);

    localparam logic [HUE_W-1:0] HUE_FULL = HUE_W'(360 << HUE_FRAC_BITS);

    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [DT_W-1:0]  dt;
    } t_job;

    typedef struct packed {
        logic [1:0]           span_hours;
        logic [HUE_DEG_W-1:0] start_hue;
        logic [MAG_W-1:0]     mag;
        logic                 neg;
    } t_seg;

    function automatic logic [4:0] point_hour(input logic [SEG_W-1:0] idx);
        logic [4:0] h;
        case (idx)
            4'd0:    h = 5'd0;
            4'd1:    h = 5'd3;
            4'd2:    h = 5'd5;
            4'd3:    h = 5'd6;
            4'd4:    h = 5'd8;
            4'd5:    h = 5'd10;
            4'd6:    h = 5'd12;
            4'd7:    h = 5'd15;
            4'd8:    h = 5'd17;
            4'd9:    h = 5'd19;
            4'd10:   h = 5'd21;
            4'd11:   h = 5'd24;
            default: h = 5'd0;
        endcase
        return h;
    endfunction

    function automatic logic [HUE_DEG_W-1:0] point_hue(input logic [SEG_W-1:0] idx);
        logic [HUE_DEG_W-1:0] c;
        case (idx)
            4'd0:    c = 9'd250;
            4'd1:    c = 9'd270;
            4'd2:    c = 9'd310;
            4'd3:    c = 9'd340;
            4'd4:    c = 9'd40;
            4'd5:    c = 9'd70;
            4'd6:    c = 9'd120;
            4'd7:    c = 9'd185;
            4'd8:    c = 9'd215;
            4'd9:    c = 9'd245;
            4'd10:   c = 9'd270;
            4'd11:   c = 9'd250;
            default: c = 9'd250;
        endcase
        return c;
    endfunction

    function automatic logic [TIME_W-1:0] point_tick(input logic [SEG_W-1:0] idx);
        return TIME_W'(int'(point_hour(idx)) * HOUR_TICKS);
    endfunction

    // Segment constants; hue step taken the short way round, in [-180, 180].
    function automatic t_seg seg_info(input logic [SEG_W-1:0] idx);
        int   h0;
        int   h1;
        int   c0;
        int   d;
        t_seg s;
        h0 = int'(point_hour(idx));
        h1 = int'(point_hour(idx + SEG_W'(1)));
        c0 = int'(point_hue(idx));
        d  = int'(point_hue(idx + SEG_W'(1))) - c0;
        if (d > 180) begin
            d = d - 360;
        end else if (d < -180) begin
            d = d + 360;
        end
        s.span_hours = 2'(h1 - h0);
        s.start_hue  = HUE_DEG_W'(c0);
        s.neg        = (d < 0);
        s.mag        = MAG_W'((d < 0) ? -d : d);
        return s;
    endfunction

    function automatic logic [DIV_W-1:0] span_div(input logic [1:0] hours);
        logic [DIV_W-1:0] v;
        case (hours)
            2'd1:    v = DIV_W'(UNIT_DIV * 1);
            2'd2:    v = DIV_W'(UNIT_DIV * 2);
            2'd3:    v = DIV_W'(UNIT_DIV * 3);
            default: v = DIV_W'(UNIT_DIV * 1);
        endcase
        return v;
    endfunction

    function automatic logic [RECIP_W-1:0] span_recip(input logic [1:0] hours);
        logic [RECIP_W-1:0] v;
        case (hours)
            2'd1:    v = RECIP_W'(RECIP_1);
            2'd2:    v = RECIP_W'(RECIP_2);
            2'd3:    v = RECIP_W'(RECIP_3);
            default: v = RECIP_W'(RECIP_1);
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/tdhi_front.sv
// Front end: takes a time item, reduces it to one day and finds its segment.
module tdhi_front import tdhi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [TIME_W-1:0] i_time_sixteenths,
    output logic              o_job_valid,
    output t_job              o_job,
    input  logic              i_queue_full
);

    logic              r_valid;
    logic              n_valid;
    t_job              r_job;
    t_job              n_job;
    logic [TIME_W-1:0] t_red;
    logic [TIME_W-1:0] t_off;
    logic              take;
    logic              push;

    assign push    = r_valid && !i_queue_full;
    assign o_stall = r_valid && i_queue_full;
    assign take    = i_valid && !o_stall;

    always_comb begin
        t_red = (i_time_sixteenths >= DAY_TICKS) ? (i_time_sixteenths - DAY_TICKS)
                                                 : i_time_sixteenths;
        // first segment whose end is not below the time (ends inclusive)
        n_job.seg = '0;
        for (int k = SEG_N - 1; k >= 0; k--) begin
            if (t_red <= point_tick(SEG_W'(k + 1))) begin
                n_job.seg = SEG_W'(k);
            end
        end
        t_off    = t_red - point_tick(n_job.seg);
        n_job.dt = t_off[DT_W-1:0];
        n_valid  = take || (r_valid && !push);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= n_job;
        end
    end

    assign o_job_valid = push;
    assign o_job       = r_job;

endmodule

// File: rtl/core/tdhi_queue.sv
// Two-entry job queue between front end and back end.
module tdhi_queue import tdhi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_job_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;

    assign o_full      = (r_count == 2'd2);
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop  ? !r_rd_ptr : r_rd_ptr;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: rtl/core/tdhi_back.sv
// Back end: four-stage interpolation pipeline with reciprocal divide and hue wrap.
module tdhi_back import tdhi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  t_job             i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [HUE_W-1:0] o_hue_value
);

    // stage valids
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    logic [SEG_W-1:0]  r_s1_seg, r_s2_seg, r_s3_seg;
    logic [PROD_W-1:0] r_s1_x, r_s2_x;
    logic [PQ_W-1:0]   r_s2_p;
    logic [Q_W-1:0]    r_s3_q;
    logic [HUE_W-1:0]  r_hue;

    logic [PROD_W-1:0] n_s1_x;
    logic [PQ_W-1:0]   n_s2_p;
    logic [Q_W-1:0]    n_s3_q;
    logic [HUE_W-1:0]  n_hue;

    t_seg              seg1, seg2, seg3, seg4;
    logic [Q_W-1:0]    q0;
    logic [R_W-1:0]    rem;
    logic [DIV_W-1:0]  div3;
    logic [HUE_W-1:0]  start_fx;
    logic [SUM_W-1:0]  sum;

    assign en4   = !r_v4 || !i_stall;
    assign en3   = !r_v3 || en4;
    assign en2   = !r_v2 || en3;
    assign en1   = !r_v1 || en2;
    assign o_pop = i_job_valid && en1;

    // stage 1: mag * dt
    always_comb begin
        seg1   = seg_info(i_job.seg);
        n_s1_x = PROD_W'(seg1.mag) * PROD_W'(i_job.dt);
    end

    // stage 2: times reciprocal of the span divisor
    always_comb begin
        seg2   = seg_info(r_s1_seg);
        n_s2_p = PQ_W'(r_s1_x) * PQ_W'(span_recip(seg2.span_hours));
    end

    // stage 3: estimate is exact or one low; fix with one compare
    always_comb begin
        seg3   = seg_info(r_s2_seg);
        div3   = span_div(seg3.span_hours);
        q0     = r_s2_p[RECIP_SHIFT +: Q_W];
        rem    = R_W'(r_s2_x) - (R_W'(q0) * R_W'(div3));
        n_s3_q = (rem >= R_W'(div3)) ? (q0 + Q_W'(1)) : q0;
    end

    // stage 4: offset from start hue, wrap into one turn
    always_comb begin
        seg4     = seg_info(r_s3_seg);
        start_fx = HUE_W'(seg4.start_hue) << HUE_FRAC_BITS;
        sum      = seg4.neg ? (SUM_W'(start_fx) - SUM_W'(r_s3_q))
                            : (SUM_W'(start_fx) + SUM_W'(r_s3_q));
        if (sum[SUM_W-1]) begin
            n_hue = sum[HUE_W-1:0] + HUE_FULL;
        end else if (sum >= SUM_W'(HUE_FULL)) begin
            n_hue = sum[HUE_W-1:0] - HUE_FULL;
        end else begin
            n_hue = sum[HUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_job_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_seg <= i_job.seg;
            r_s1_x   <= n_s1_x;
        end
        if (en2) begin
            r_s2_seg <= r_s1_seg;
            r_s2_x   <= r_s1_x;
            r_s2_p   <= n_s2_p;
        end
        if (en3) begin
            r_s3_seg <= r_s2_seg;
            r_s3_q   <= n_s3_q;
        end
        if (en4) begin
            r_hue <= n_hue;
        end
    end

    assign o_valid     = r_v4;
    assign o_hue_value = r_hue;

endmodule

// File: rtl/core/time_of_day_hue_interpolator.sv
// Top level of the time-of-day hue interpolator.
// Each item carries a time of day in 1/16 s; times of one day or more have
// a day taken off. The time is placed in the first of eleven fixed
// breakpoint segments (0,3,5,6,8,10,12,15,17,19,21,24 h) that holds it,
// a breakpoint itself belonging to the earlier segment, and the hue is
// interpolated from the segment's start hue toward its end hue the short
// way round the circle, truncated, wrapped into [0, 360) degrees, and given
// in 1/64 degree. The block holds no state between items.
// Throughput is one item per clock while nothing stalls. The front end register is
// loaded at the accept edge (day reduction and segment search ahead of it).
// The item then passes through the two-entry job queue. Three back end
// stages follow (multiply, reciprocal multiply, remainder correction), and
// then the output register (add and wrap). With the back end full, the front
// end still takes items under output stall until the job queue is full, and
// only then does o_stall rise. o_stall never depends on i_stall in the same
// cycle, and o_valid is a register output.
module time_of_day_hue_interpolator import tdhi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [TIME_W-1:0] i_time_sixteenths,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [HUE_W-1:0]  o_hue_value
);

    // front end -> queue
    logic push;
    t_job front_job;
    logic queue_full;

    // queue -> back end
    logic queue_valid;
    t_job queue_job;
    logic pop;

    tdhi_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_time_sixteenths (i_time_sixteenths),
        .o_job_valid       (push),
        .o_job             (front_job),
        .i_queue_full      (queue_full)
    );

    tdhi_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_job       (front_job),
        .o_full      (queue_full),
        .o_job_valid (queue_valid),
        .o_job       (queue_job),
        .i_pop       (pop)
    );

    tdhi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_hue_value (o_hue_value)
    );

endmodule

// File: rtl/core/tdhi_checker.sv
// Port-level checks for the hue interpolator, bound to the top level.
`include "assert_macros.svh"

module tdhi_checker import tdhi_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic [HUE_W-1:0] o_hue_value
);

    // output item held while stalled
    `ASSERT_CLK(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_hue_value))

    // hue always inside one turn
    `ASSERT_CLK(a_hue_range, o_valid |-> o_hue_value < HUE_FULL)

    // pipeline empty in the cycle after reset
    `ASSERT_CLK(a_reset_empty, $past(!i_rst_n) |-> !o_valid)

    // input stall can only rise right after an item was taken
    `ASSERT_CLK(a_stall_rise, $rose(o_stall) |-> $past(i_valid && !o_stall))

endmodule

bind time_of_day_hue_interpolator tdhi_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_hue_value (o_hue_value)
);
